### hw/rtl/mesh_packet_header_parse_hash_core_assert.svh
// Assertion macros used by the checker of this block.
// Each expects clk and rst_n in scope.
`ifndef MESH_PACKET_HEADER_PARSE_HASH_CORE_ASSERT_SVH
`define MESH_PACKET_HEADER_PARSE_HASH_CORE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define MPHP_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mphp assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define MPHP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mphp assertion failed");

`endif

### hw/rtl/mphp_pkg.sv
package mphp_pkg;

  localparam int MAX_PACKET_BYTES_DEF = 1024;

  // configuration register indexes
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 4;
  localparam logic [CFG_IDX_W-1:0] CFG_FLOOD_CODE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DIRECT_CODE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TRACE_CODE  = 2'd2;

  localparam logic [1:0] FLOOD_CODE_RST  = 2'd0;
  localparam logic [1:0] DIRECT_CODE_RST = 2'd3;
  localparam logic [3:0] TRACE_CODE_RST  = 4'd9;

  // result status codes
  localparam int STATUS_W = 3;
  localparam logic [STATUS_W-1:0] ST_OK             = 3'd0;
  localparam logic [STATUS_W-1:0] ST_SHORT_PACKET   = 3'd1;
  localparam logic [STATUS_W-1:0] ST_SHORT_TRANSPORT = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NO_PATH_LEN    = 3'd3;
  localparam logic [STATUS_W-1:0] ST_SHORT_PATH     = 3'd4;

  localparam int TRACE_MIN_BYTES = 13;
  localparam int TAG_BYTES       = 4;
  localparam int TRANSPORT_BYTES = 4;
  localparam logic [7:0] HASH_SEED_MASK = 8'hFC;

  // fixed-width part of the result beat, everything but the two lengths
  localparam int OUT_FIXED_W = 2 + 4 + 2 + 16 + 16 + 8 + 32 + STATUS_W + 1;

  function automatic int len_width(input int max_bytes);
    return $clog2(max_bytes + 1);
  endfunction

  function automatic int out_data_width(input int max_bytes);
    int raw;
    raw = OUT_FIXED_W + 2 * len_width(max_bytes);
    return ((raw + 7) / 8) * 8;
  endfunction

endpackage

### hw/rtl/mesh_packet_header_parse_hash_core.sv
// Packet header parser and message hash. Packet bytes enter one per cycle on
// the in_ stream, in wire order, with in_tlast on the final byte; each packet
// yields one result beat on the out_ stream, registered, in the cycle after its
// last byte is taken. The field step and the times-31 hash update (shift,
// subtract, add on 32 bits) both finish in the cycle a byte is accepted, so
// the sustained rate is one byte per cycle; in_tready drops only while the
// output register holds a result that the consumer has not yet taken.
// Result status: 0 ok, 1 fewer than two bytes, 2 transport codes cut short,
// 3 path length byte missing, 4 path cut short. The hash and the payload
// length are valid only with status 0. Configuration writes are expected
// only between packets.
module mesh_packet_header_parse_hash_core
  import mphp_pkg::*;
#(
  parameter int MAX_PACKET_BYTES = MAX_PACKET_BYTES_DEF,
  parameter int LEN_W            = len_width(MAX_PACKET_BYTES),
  parameter int OUT_DATA_W       = out_data_width(MAX_PACKET_BYTES)
) (
  input  logic                  clk,
  input  logic                  rst_n,

  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [7:0]            in_tdata,   // data_byte[7:0]
  input  logic                  in_tlast,   // last_byte

  output logic                  out_tvalid,
  input  logic                  out_tready,
  // route_type[2], payload_type[4], payload_version[2], transport_code_first[16],
  // transport_code_second[16], path_length[8], payload_length[LEN_W],
  // total_length[LEN_W], message_hash[32], status[3], payload_empty[1], zero pad
  output logic [OUT_DATA_W-1:0] out_tdata,
  output logic                  out_tuser,  // hash_from_trace_tag

  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam logic [2:0] PH_HEADER    = 3'd0;
  localparam logic [2:0] PH_TRANSPORT = 3'd1;
  localparam logic [2:0] PH_PATHLEN   = 3'd2;
  localparam logic [2:0] PH_PATH      = 3'd3;
  localparam logic [2:0] PH_PAYLOAD   = 3'd4;

  localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_PACKET_BYTES);
  localparam int RAW_W = OUT_FIXED_W + 2 * LEN_W;
  localparam int PAD_W = OUT_DATA_W - RAW_W;

  logic [1:0]  flood_code_r;
  logic [1:0]  direct_code_r;
  logic [3:0]  trace_code_r;

  logic [2:0]       phase_r, phase_nxt;
  logic [7:0]       header_r, header_nxt;
  logic [31:0]      transport_r, transport_nxt;
  logic [2:0]       fcount_r, fcount_nxt;
  logic [7:0]       path_len_r, path_len_nxt;
  logic [7:0]       path_rem_r, path_rem_nxt;
  logic [LEN_W-1:0] byte_cnt_r, byte_cnt_nxt;
  logic [LEN_W-1:0] pay_cnt_r, pay_cnt_nxt;
  logic [31:0]      hash_r, hash_nxt;
  logic [31:0]      tag_r, tag_nxt;

  logic                  out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r, out_data_nxt;
  logic                  out_user_r, out_user_nxt;

  logic                  in_beat;
  logic [1:0]            route;
  logic [STATUS_W-1:0]   status;
  logic [15:0]           tc_first, tc_second;
  logic [LEN_W-1:0]      res_plen;
  logic [31:0]           res_hash;
  logic                  res_tag;
  logic                  res_empty;
  logic                  use_tag;

  assign in_tready  = !out_valid_r || out_tready;
  assign in_beat    = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;
  assign route      = in_tdata[1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flood_code_r  <= FLOOD_CODE_RST;
      direct_code_r <= DIRECT_CODE_RST;
      trace_code_r  <= TRACE_CODE_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_FLOOD_CODE:  flood_code_r  <= cfg_wdata[1:0];
        CFG_DIRECT_CODE: direct_code_r <= cfg_wdata[1:0];
        CFG_TRACE_CODE:  trace_code_r  <= cfg_wdata[3:0];
        default: ;
      endcase
    end
  end

  // field step and hash update for the byte being taken
  always_comb begin
    phase_nxt     = phase_r;
    header_nxt    = header_r;
    transport_nxt = transport_r;
    fcount_nxt    = fcount_r;
    path_len_nxt  = path_len_r;
    path_rem_nxt  = path_rem_r;
    pay_cnt_nxt   = pay_cnt_r;
    hash_nxt      = hash_r;
    tag_nxt       = tag_r;
    byte_cnt_nxt  = (byte_cnt_r < LEN_MAX) ? byte_cnt_r + 1'b1 : LEN_MAX;

    unique case (phase_r)
      PH_HEADER: begin
        header_nxt = in_tdata;
        hash_nxt   = {24'd0, in_tdata & HASH_SEED_MASK};
        phase_nxt  = (route == flood_code_r || route == direct_code_r) ?
                     PH_TRANSPORT : PH_PATHLEN;
      end
      PH_TRANSPORT: begin
        transport_nxt = transport_r | ({24'd0, in_tdata} << {fcount_r[1:0], 3'b000});
        fcount_nxt    = fcount_r + 1'b1;
        if (fcount_nxt >= 3'(TRANSPORT_BYTES)) phase_nxt = PH_PATHLEN;
      end
      PH_PATHLEN: begin
        path_len_nxt = in_tdata;
        path_rem_nxt = in_tdata;
        phase_nxt    = (in_tdata == 8'd0) ? PH_PAYLOAD : PH_PATH;
      end
      PH_PATH: begin
        path_rem_nxt = path_rem_r - 1'b1;
        if (path_rem_nxt == 8'd0) phase_nxt = PH_PAYLOAD;
      end
      default: begin
        if (pay_cnt_r < LEN_W'(TAG_BYTES))
          tag_nxt = tag_r | ({24'd0, in_tdata} << {pay_cnt_r[1:0], 3'b000});
        pay_cnt_nxt = (pay_cnt_r < LEN_MAX) ? pay_cnt_r + 1'b1 : LEN_MAX;
        // h*31 + b
        hash_nxt = {hash_r[26:0], 5'b00000} - hash_r + {24'd0, in_tdata};
      end
    endcase
  end

  // result formed from the state after the last byte
  always_comb begin
    if (byte_cnt_nxt < LEN_W'(2))      status = ST_SHORT_PACKET;
    else if (phase_nxt == PH_TRANSPORT) status = ST_SHORT_TRANSPORT;
    else if (phase_nxt == PH_PATHLEN)   status = ST_NO_PATH_LEN;
    else if (phase_nxt == PH_PATH)      status = ST_SHORT_PATH;
    else                                status = ST_OK;

    if (fcount_nxt >= 3'(TRANSPORT_BYTES)) begin
      tc_first  = transport_nxt[15:0];
      tc_second = transport_nxt[31:16];
    end else begin
      tc_first  = 16'd0;
      tc_second = 16'd0;
    end

    use_tag = (header_nxt[5:2] == trace_code_r) &&
              (byte_cnt_nxt >= LEN_W'(TRACE_MIN_BYTES)) &&
              (pay_cnt_nxt >= LEN_W'(TAG_BYTES));

    if (status == ST_OK) begin
      res_plen  = pay_cnt_nxt;
      res_empty = (pay_cnt_nxt == '0);
      res_tag   = use_tag;
      res_hash  = use_tag ? tag_nxt : hash_nxt;
    end else begin
      res_plen  = '0;
      res_empty = 1'b1;
      res_tag   = 1'b0;
      res_hash  = 32'd0;
    end

    out_data_nxt = {{PAD_W{1'b0}}, res_empty, status, res_hash, byte_cnt_nxt, res_plen,
                    path_len_nxt, tc_second, tc_first, header_nxt[7:6], header_nxt[5:2],
                    header_nxt[1:0]};
    out_user_nxt = res_tag;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_HEADER;
      header_r    <= '0;
      transport_r <= '0;
      fcount_r    <= '0;
      path_len_r  <= '0;
      path_rem_r  <= '0;
      byte_cnt_r  <= '0;
      pay_cnt_r   <= '0;
      hash_r      <= '0;
      tag_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_beat && in_tlast) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end
      if (in_beat) begin
        if (in_tlast) begin
          phase_r     <= PH_HEADER;
          header_r    <= '0;
          transport_r <= '0;
          fcount_r    <= '0;
          path_len_r  <= '0;
          path_rem_r  <= '0;
          byte_cnt_r  <= '0;
          pay_cnt_r   <= '0;
          hash_r      <= '0;
          tag_r       <= '0;
        end else begin
          phase_r     <= phase_nxt;
          header_r    <= header_nxt;
          transport_r <= transport_nxt;
          fcount_r    <= fcount_nxt;
          path_len_r  <= path_len_nxt;
          path_rem_r  <= path_rem_nxt;
          byte_cnt_r  <= byte_cnt_nxt;
          pay_cnt_r   <= pay_cnt_nxt;
          hash_r      <= hash_nxt;
          tag_r       <= tag_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_beat && in_tlast) begin
      out_data_r <= out_data_nxt;
      out_user_r <= out_user_nxt;
    end
  end

endmodule

### hw/rtl/mphp_checker.sv
`include "mesh_packet_header_parse_hash_core_assert.svh"

module mphp_checker
  import mphp_pkg::*;
#(
  parameter int MAX_PACKET_BYTES = MAX_PACKET_BYTES_DEF,
  parameter int LEN_W            = len_width(MAX_PACKET_BYTES),
  parameter int OUT_DATA_W       = out_data_width(MAX_PACKET_BYTES)
) (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_tready,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata,
  input logic                  out_tuser
);

  localparam int PLEN_LSB   = 48;
  localparam int TOTAL_LSB  = PLEN_LSB + LEN_W;
  localparam int HASH_LSB   = TOTAL_LSB + LEN_W;
  localparam int STATUS_LSB = HASH_LSB + 32;
  localparam int EMPTY_BIT  = STATUS_LSB + STATUS_W;

  logic [LEN_W-1:0]    plen;
  logic [LEN_W-1:0]    total;
  logic [31:0]         hash;
  logic [STATUS_W-1:0] status;
  logic                empty;

  assign plen   = out_tdata[PLEN_LSB +: LEN_W];
  assign total  = out_tdata[TOTAL_LSB +: LEN_W];
  assign hash   = out_tdata[HASH_LSB +: 32];
  assign status = out_tdata[STATUS_LSB +: STATUS_W];
  assign empty  = out_tdata[EMPTY_BIT];

  // a failed parse reports no hash and no payload
  `MPHP_ASSERT_NOW(a_fail_clears, out_tvalid && (status != ST_OK),
                   (hash == 32'd0) && !out_tuser && (plen == '0) && empty)

  `MPHP_ASSERT_NOW(a_short_status, out_tvalid,
                   (status == ST_SHORT_PACKET) == (total < LEN_W'(2)))

  `MPHP_ASSERT_NOW(a_tag_terms, out_tvalid && out_tuser,
                   (status == ST_OK) && (plen >= LEN_W'(TAG_BYTES)) &&
                   (total >= LEN_W'(TRACE_MIN_BYTES)))

  // input is never blocked by an empty output register
  `MPHP_ASSERT_NOW(a_ready_when_empty, !out_tvalid, in_tready)

  `MPHP_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready,
                    out_tvalid && $stable(out_tdata) && $stable(out_tuser))

endmodule

bind mesh_packet_header_parse_hash_core mphp_checker #(
  .MAX_PACKET_BYTES(MAX_PACKET_BYTES),
  .LEN_W           (LEN_W),
  .OUT_DATA_W      (OUT_DATA_W)
) u_mphp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_tready (in_tready),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready),
  .out_tdata (out_tdata),
  .out_tuser (out_tuser)
);
